[src/prt_pkg.sv]
package prt_pkg;

   // opcodes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   // response status codes
   localparam logic [2:0] ST_UPDATED  = 3'd0;
   localparam logic [2:0] ST_APPENDED = 3'd1;
   localparam logic [2:0] ST_REPLACED = 3'd2;
   localparam logic [2:0] ST_HIT      = 3'd3;
   localparam logic [2:0] ST_MISS     = 3'd4;

   localparam logic signed [63:0] TIME_MIN = {1'b1, 63'd0};
   localparam logic signed [63:0] TIME_MAX = {1'b0, {63{1'b1}}};

   typedef struct packed {
      logic               opcode;
      logic [47:0]        device_address;
      logic [7:0]         address_type;
      logic signed [63:0] conn_time;
      logic [7:0]         peer_priority;
      logic signed [7:0]  signal_strength;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [3:0]         slot;
      logic signed [63:0] stored_time;
      logic [4:0]         record_count;
      logic [3:0]         oldest_slot_out;
   } rsp_type;

   // one table record as held in memory
   typedef struct packed {
      logic [55:0]        key;
      logic signed [63:0] rec_time;
      logic [7:0]         rec_priority;
      logic [7:0]         rec_rssi;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   // response load from sequencer to output stage
   typedef struct packed {
      logic    load;
      rsp_type data;
   } rsp_load_type;

endpackage

[src/peer_record_table_oldest_replace.sv]
// peer record table: up to ENTRIES records keyed by {address type, 48-bit address}, each
// holding a signed 64-bit connection time, a priority and an rssi, all kept in one
// single-port-read, single-port-write memory with registered read data. an insert request
// first searches the valid slots in order for its key, one memory read per cycle; a hit
// rewrites that slot, a miss appends while there is room and otherwise overwrites the slot
// with the oldest time. after every insert a second pass over the valid slots finds the
// oldest time again (smallest signed value, lowest index on ties). a query request returns
// the stored time, or the most negative value with slot 0 on a miss, and leaves the table
// as it is. one request is in work at a time; an insert makes both the search pass and the
// oldest-time pass, a query only the search pass, and the two passes share the one memory
// read port. the response sits in an output register, so a new request is taken while
// the last response waits.
// the table starts empty after reset, no memory clearing is needed.
module peer_record_table_oldest_replace
   import prt_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic    clock,
   input  logic    reset,
   // request channel
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   // response channel
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IDX_W = $clog2(ENTRIES);

   // memory port signals
   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   rec_type          mem_wr_data;
   logic [IDX_W-1:0] mem_rd_addr;
   logic [REC_W-1:0] mem_rd_raw;
   rec_type          mem_rd_data;

   // sequencer to output register
   rsp_load_type     out_load;
   logic             out_free;

   assign mem_rd_data = rec_type'(mem_rd_raw);

   // search, write and oldest-scan sequencer
   prt_ctrl #(
      .ENTRIES (ENTRIES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .out_free    (out_free),
      .out_load    (out_load)
   );

   // record memory: key, time, priority and rssi per slot
   prt_ram #(
      .WIDTH (REC_W),
      .DEPTH (ENTRIES)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (REC_W'(mem_wr_data)),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_raw)
   );

   // response register, decouples the sequencer from a stalled consumer
   prt_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load_in   (out_load),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[src/prt_ram.sv]
module prt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/prt_out.sv]
module prt_out
   import prt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  rsp_load_type load_in,
   output logic         free,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data
);

   logic    valid_ff;
   rsp_type data_ff;

   assign free = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load_in.load) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
      if (load_in.load) begin
         data_ff <= load_in.data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

[src/prt_ctrl.sv]
module prt_ctrl
   import prt_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_type                    req_data,
   output logic                       mem_wr_en,
   output logic [$clog2(ENTRIES)-1:0] mem_wr_addr,
   output rec_type                    mem_wr_data,
   output logic [$clog2(ENTRIES)-1:0] mem_rd_addr,
   input  rec_type                    mem_rd_data,
   input  logic                       out_free,
   output rsp_load_type               out_load
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_WRITE,
      S_SCAN,
      S_DONE
   } state_type;

   state_type          state_ff;
   req_type            req_ff;
   logic [CNT_W-1:0]   addr_ff;
   logic [IDX_W-1:0]   chk_ff;
   logic               chk_valid_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [IDX_W-1:0]   oldest_ff;
   logic [IDX_W-1:0]   slot_ff;
   logic [2:0]         status_ff;
   logic signed [63:0] time_ff;
   logic signed [63:0] min_ff;
   logic [IDX_W-1:0]   best_ff;

   logic [55:0]        req_key;
   logic               issue;
   logic               key_match;
   logic               older;
   logic [IDX_W-1:0]   best_in;
   logic signed [63:0] min_in;

   assign req_key   = {req_ff.address_type, req_ff.device_address};
   assign issue     = addr_ff < count_ff;
   assign key_match = chk_valid_ff && (mem_rd_data.key == req_key);
   assign older     = chk_valid_ff && (mem_rd_data.rec_time < min_ff);
   assign best_in   = older ? chk_ff : best_ff;
   assign min_in    = older ? mem_rd_data.rec_time : min_ff;

   assign req_stall   = state_ff != S_IDLE;
   assign mem_rd_addr = addr_ff[IDX_W-1:0];
   assign mem_wr_en   = state_ff == S_WRITE;
   assign mem_wr_addr = slot_ff;
   assign mem_wr_data = '{key:          req_key,
                          rec_time:     req_ff.conn_time,
                          rec_priority: req_ff.peer_priority,
                          rec_rssi:     req_ff.signal_strength};

   assign out_load.load                 = (state_ff == S_DONE) && out_free;
   assign out_load.data.status          = status_ff;
   assign out_load.data.slot            = 4'(slot_ff);
   assign out_load.data.stored_time     = time_ff;
   assign out_load.data.record_count    = 5'(count_ff);
   assign out_load.data.oldest_slot_out = 4'(oldest_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         oldest_ff    <= '0;
         chk_valid_ff <= 1'b0;
         addr_ff      <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff       <= req_data;
                  addr_ff      <= '0;
                  chk_valid_ff <= 1'b0;
                  state_ff     <= S_SEARCH;
               end
            end
            S_SEARCH: begin
               if (key_match || !issue) begin
                  chk_valid_ff <= 1'b0;
                  if (req_ff.opcode == OP_QUERY) begin
                     status_ff <= key_match ? ST_HIT : ST_MISS;
                     slot_ff   <= key_match ? chk_ff : '0;
                     time_ff   <= key_match ? mem_rd_data.rec_time : TIME_MIN;
                     state_ff  <= S_DONE;
                  end else begin
                     time_ff  <= '0;
                     state_ff <= S_WRITE;
                     priority if (key_match) begin
                        status_ff <= ST_UPDATED;
                        slot_ff   <= chk_ff;
                     end else if (count_ff < CNT_W'(ENTRIES)) begin
                        status_ff <= ST_APPENDED;
                        slot_ff   <= count_ff[IDX_W-1:0];
                     end else begin
                        status_ff <= ST_REPLACED;
                        slot_ff   <= oldest_ff;
                     end
                  end
               end else begin
                  chk_ff       <= addr_ff[IDX_W-1:0];
                  chk_valid_ff <= 1'b1;
                  addr_ff      <= addr_ff + 1'b1;
               end
            end
            S_WRITE: begin
               if (status_ff == ST_APPENDED) begin
                  count_ff <= count_ff + 1'b1;
               end
               addr_ff      <= '0;
               chk_valid_ff <= 1'b0;
               min_ff       <= TIME_MAX;
               best_ff      <= '0;
               state_ff     <= S_SCAN;
            end
            S_SCAN: begin
               min_ff  <= min_in;
               best_ff <= best_in;
               if (issue) begin
                  chk_ff       <= addr_ff[IDX_W-1:0];
                  chk_valid_ff <= 1'b1;
                  addr_ff      <= addr_ff + 1'b1;
               end else begin
                  chk_valid_ff <= 1'b0;
                  oldest_ff    <= best_in;
                  state_ff     <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
